// ----- rtl/core/fewt_pkg.sv -----
`default_nettype none
package fewt_pkg;

  localparam int ODO_W   = 27;
  localparam int FUEL_W  = 16;
  localparam int TOT_W   = 40;
  localparam int MPG_W   = 16;
  localparam int SCALE_W = 14;
  localparam int DIV_W   = TOT_W + MPG_W;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 32;
  localparam int QDEPTH  = 2;

  localparam logic [ADDR_W-1:0]  REG_START_ODO = '0;

  localparam logic [SCALE_W-1:0] MPG_SCALE = SCALE_W'(10000);
  localparam logic [MPG_W-1:0]   MPG_MAX   = '1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef enum logic [1:0] {
    SEL_CUR,
    SEL_TOT,
    SEL_ROL
  } sel_t;

  typedef struct packed {
    logic load;
    logic store_zero;
    logic store_sat;
    logic div_start;
    logic div_step;
    logic out_load;
  } bk_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/fewt_front.sv -----
`default_nettype none
module fewt_front import fewt_pkg::*; #(
  parameter int WINDOW_LEN = 5,
  parameter int DS_W       = 30,
  parameter int FS_W       = 19
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ODO_W-1:0]  cfg_wdata,
  output logic      [ODO_W-1:0]  start_odo,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ODO_W-1:0]  in_odometer,
  input  wire logic [FUEL_W-1:0] in_fuel,
  input  wire logic              q_full,
  output logic                   job_push,
  output logic      [ODO_W-1:0]  job_dist,
  output logic      [ODO_W-1:0]  job_tdist,
  output logic      [DS_W-1:0]   job_dsum,
  output logic      [FUEL_W-1:0] job_fuel,
  output logic      [TOT_W-1:0]  job_ftot,
  output logic      [FS_W-1:0]   job_fsum,
  output logic                   job_back
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  logic [ODO_W-1:0]  start_r;
  logic [ODO_W-1:0]  prev_r;
  logic [TOT_W-1:0]  ftot_r, ftot_nxt;
  logic [DS_W-1:0]   dsum_r, dsum_nxt;
  logic [FS_W-1:0]   fsum_r, fsum_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ODO_W-1:0]  ring_d_r [WINDOW_LEN];
  logic [FUEL_W-1:0] ring_f_r [WINDOW_LEN];

  logic              back;
  logic [ODO_W-1:0]  trip;
  logic [ODO_W-1:0]  tdist;
  logic [TOT_W:0]    ftot_sum;
  logic              full;
  logic [ODO_W-1:0]  old_d;
  logic [FUEL_W-1:0] old_f;

  assign in_ready  = !q_full;
  assign job_push  = in_valid && in_ready;
  assign start_odo = start_r;

  always_comb begin
    back     = in_odometer < prev_r;
    trip     = back ? '0 : in_odometer - prev_r;
    tdist    = (in_odometer >= start_r) ? in_odometer - start_r : '0;
    ftot_sum = {1'b0, ftot_r} + (TOT_W + 1)'(in_fuel);
    ftot_nxt = ftot_sum[TOT_W] ? '1 : ftot_sum[TOT_W-1:0];
    full     = fill_r == FILL_W'(WINDOW_LEN);
    old_d    = full ? ring_d_r[slot_r] : '0;
    old_f    = full ? ring_f_r[slot_r] : '0;
    dsum_nxt = dsum_r - DS_W'(old_d) + DS_W'(trip);
    fsum_nxt = fsum_r - FS_W'(old_f) + FS_W'(in_fuel);
    fill_nxt = full ? fill_r : fill_r + FILL_W'(1);
    slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
  end

  assign job_dist  = trip;
  assign job_tdist = tdist;
  assign job_dsum  = dsum_nxt;
  assign job_fuel  = in_fuel;
  assign job_ftot  = ftot_nxt;
  assign job_fsum  = fsum_nxt;
  assign job_back  = back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      prev_r  <= '0;
      ftot_r  <= '0;
      dsum_r  <= '0;
      fsum_r  <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
    end else if (cfg_we) begin
      start_r <= cfg_wdata;
      prev_r  <= cfg_wdata;
    end else if (job_push) begin
      prev_r <= in_odometer;
      ftot_r <= ftot_nxt;
      dsum_r <= dsum_nxt;
      fsum_r <= fsum_nxt;
      fill_r <= fill_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      ring_d_r[slot_r] <= trip;
      ring_f_r[slot_r] <= in_fuel;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fewt_fifo.sv -----
`default_nettype none
module fewt_fifo import fewt_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = cnt_r == CNT_W'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

// ----- rtl/core/fewt_back.sv -----
`default_nettype none
module fewt_back import fewt_pkg::*; #(
  parameter int DS_W = 30,
  parameter int FS_W = 19
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic [ODO_W-1:0]  job_dist,
  input  wire logic [ODO_W-1:0]  job_tdist,
  input  wire logic [DS_W-1:0]   job_dsum,
  input  wire logic [FUEL_W-1:0] job_fuel,
  input  wire logic [TOT_W-1:0]  job_ftot,
  input  wire logic [FS_W-1:0]   job_fsum,
  input  wire logic              job_back,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [MPG_W-1:0]  out_current_mpg,
  output logic      [MPG_W-1:0]  out_total_mpg,
  output logic      [MPG_W-1:0]  out_rolling_mpg,
  output logic                   out_current_valid,
  output logic                   out_total_valid,
  output logic                   out_rolling_valid,
  output logic                   out_odometer_backwards
);

  localparam int SRC_W  = DS_W;
  localparam int PROD_W = SRC_W + SCALE_W;
  localparam int CNT_W  = $clog2(MPG_W);

  bk_state_t         state_r, state_nxt;
  sel_t              sel_r;
  bk_ctl_t           ctl;
  logic [DIV_W-1:0]  num_r, rem_r, dsh_r;
  logic [TOT_W-1:0]  den_r;
  logic [MPG_W-1:0]  q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MPG_W-1:0]  cur_q_r, tot_q_r, rol_q_r;
  logic              cur_v_r, tot_v_r, rol_v_r;
  logic              out_valid_r;

  logic [SRC_W-1:0]  src;
  logic [TOT_W-1:0]  den_sel;
  logic              den_zero, sat, ge, last_sel, last_bit;
  logic [MPG_W-1:0]  q_step;
  logic              st_en, st_v;
  logic [MPG_W-1:0]  st_q;

  always_comb begin
    case (sel_r)
      SEL_CUR: begin
        src     = SRC_W'(job_dist);
        den_sel = TOT_W'(job_fuel);
      end
      SEL_TOT: begin
        src     = SRC_W'(job_tdist);
        den_sel = job_ftot;
      end
      SEL_ROL: begin
        src     = job_dsum;
        den_sel = TOT_W'(job_fsum);
      end
      default: begin
        src     = '0;
        den_sel = '0;
      end
    endcase
  end

  assign den_zero = den_r == '0;
  assign sat      = num_r >= {den_r, {MPG_W{1'b0}}};
  assign ge       = rem_r >= dsh_r;
  assign q_step   = {q_r[MPG_W-2:0], ge};
  assign last_sel = sel_r == SEL_ROL;
  assign last_bit = cnt_r == '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = BK_LOAD;
      BK_LOAD:  state_nxt = BK_CHECK;
      BK_CHECK: begin
        if (den_zero || sat) state_nxt = last_sel ? BK_DONE : BK_LOAD;
        else state_nxt = BK_DIV;
      end
      BK_DIV:   if (last_bit) state_nxt = last_sel ? BK_DONE : BK_LOAD;
      BK_DONE:  if (!out_valid_r || out_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      BK_LOAD:  ctl.load = 1'b1;
      BK_CHECK: begin
        ctl.store_zero = den_zero;
        ctl.store_sat  = !den_zero && sat;
        ctl.div_start  = !den_zero && !sat;
      end
      BK_DIV:   ctl.div_step = 1'b1;
      BK_DONE:  ctl.out_load = !out_valid_r || out_ready;
      default:  ctl = '0;
    endcase
  end

  always_comb begin
    st_en = ctl.store_zero || ctl.store_sat || (ctl.div_step && last_bit);
    st_v  = !ctl.store_zero;
    if (ctl.store_zero)     st_q = '0;
    else if (ctl.store_sat) st_q = MPG_MAX;
    else                    st_q = q_step;
  end

  assign q_pop = ctl.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sel_r       <= SEL_CUR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE) sel_r <= SEL_CUR;
      else if (st_en) begin
        case (sel_r)
          SEL_CUR: sel_r <= SEL_TOT;
          SEL_TOT: sel_r <= SEL_ROL;
          default: sel_r <= SEL_ROL;
        endcase
      end
      if (ctl.out_load)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num_r <= DIV_W'(PROD_W'(src) * PROD_W'(MPG_SCALE));
      den_r <= den_sel;
    end
    if (ctl.div_start) begin
      rem_r <= num_r;
      dsh_r <= DIV_W'({den_r, {(MPG_W - 1){1'b0}}});
      q_r   <= '0;
      cnt_r <= CNT_W'(MPG_W - 1);
    end else if (ctl.div_step) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= q_step;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (st_en) begin
      case (sel_r)
        SEL_CUR: begin
          cur_q_r <= st_q;
          cur_v_r <= st_v;
        end
        SEL_TOT: begin
          tot_q_r <= st_q;
          tot_v_r <= st_v;
        end
        default: begin
          rol_q_r <= st_q;
          rol_v_r <= st_v;
        end
      endcase
    end
    if (ctl.out_load) begin
      out_current_mpg        <= cur_q_r;
      out_total_mpg          <= tot_q_r;
      out_rolling_mpg        <= rol_q_r;
      out_current_valid      <= cur_v_r;
      out_total_valid        <= tot_v_r;
      out_rolling_valid      <= rol_v_r;
      out_odometer_backwards <= job_back;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/fuel_economy_window_tracker.sv -----
// Path from acceptance to result, with the back end idle:
//   queue pass (idle) + 3 quotients x (load + check + 16 restoring steps) + done.
//   A zero or saturated quotient skips its 16 steps.
// All three quotients share one divider; new words queue (two entries) meanwhile.
// Reset: rst_n synchronous, clears start reading, totals, window and queue.
`default_nettype none
module fuel_economy_window_tracker import fewt_pkg::*; #(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ODO_W-1:0]  in_odometer,
  input  wire logic [FUEL_W-1:0] in_fuel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [MPG_W-1:0]  out_current_mpg,
  output logic      [MPG_W-1:0]  out_total_mpg,
  output logic      [MPG_W-1:0]  out_rolling_mpg,
  output logic                   out_current_valid,
  output logic                   out_total_valid,
  output logic                   out_rolling_valid,
  output logic                   out_odometer_backwards
);

  localparam int GROW  = $clog2(WINDOW_LEN + 1);
  localparam int DS_W  = ODO_W + GROW;
  localparam int FS_W  = FUEL_W + GROW;
  localparam int JOB_W = 2 * ODO_W + DS_W + FUEL_W + TOT_W + FS_W + 1;

  logic              cfg_we;
  logic [ODO_W-1:0]  start_odo;
  logic              q_full, q_empty, q_push, q_pop;
  logic [JOB_W-1:0]  q_wdata, q_rdata;

  logic [ODO_W-1:0]  f_dist, f_tdist, b_dist, b_tdist;
  logic [DS_W-1:0]   f_dsum, b_dsum;
  logic [FUEL_W-1:0] f_fuel, b_fuel;
  logic [TOT_W-1:0]  f_ftot, b_ftot;
  logic [FS_W-1:0]   f_fsum, b_fsum;
  logic              f_back, b_back;

  // start register is the only one, at byte address 0
  assign cfg_we = psel && penable && pwrite && (paddr == REG_START_ODO);
  assign pready = 1'b1;
  assign prdata = {{(DATA_W - ODO_W){1'b0}}, start_odo};

  fewt_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .DS_W       (DS_W),
    .FS_W       (FS_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[ODO_W-1:0]),
    .start_odo   (start_odo),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_odometer (in_odometer),
    .in_fuel     (in_fuel),
    .q_full      (q_full),
    .job_push    (q_push),
    .job_dist    (f_dist),
    .job_tdist   (f_tdist),
    .job_dsum    (f_dsum),
    .job_fuel    (f_fuel),
    .job_ftot    (f_ftot),
    .job_fsum    (f_fsum),
    .job_back    (f_back)
  );

  assign q_wdata = {f_dist, f_tdist, f_dsum, f_fuel, f_ftot, f_fsum, f_back};

  fewt_fifo #(
    .W (JOB_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_dist, b_tdist, b_dsum, b_fuel, b_ftot, b_fsum, b_back} = q_rdata;

  fewt_back #(
    .DS_W (DS_W),
    .FS_W (FS_W)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_pop                  (q_pop),
    .job_dist               (b_dist),
    .job_tdist              (b_tdist),
    .job_dsum               (b_dsum),
    .job_fuel               (b_fuel),
    .job_ftot               (b_ftot),
    .job_fsum               (b_fsum),
    .job_back               (b_back),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_current_mpg        (out_current_mpg),
    .out_total_mpg          (out_total_mpg),
    .out_rolling_mpg        (out_rolling_mpg),
    .out_current_valid      (out_current_valid),
    .out_total_valid        (out_total_valid),
    .out_rolling_valid      (out_rolling_valid),
    .out_odometer_backwards (out_odometer_backwards)
  );

endmodule
`default_nettype wire
